// ===== rtl/can_ida_pkg.sv =====
package can_ida_pkg;

	localparam int ID_W    = 29;
	localparam int DLC_W   = 4;
	localparam int TIME_W  = 32;
	localparam int CNT_W   = 32;
	localparam int UNIQ_W  = 10;
	localparam int CMD_W   = 2;
	localparam int FLAG_W  = 2;

	// Input tdata: can_id, frame_dlc, time_ms, padded to whole bytes.
	localparam int IN_FIELDS_W  = ID_W + DLC_W + TIME_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	// Output tdata: entry_dlc, message_count, first_seen, last_seen, unique_count.
	localparam int OUT_FIELDS_W = DLC_W + CNT_W + TIME_W + TIME_W + UNIQ_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_OBSERVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [DLC_W-1:0]  dlc;
		logic [TIME_W-1:0] first;
		logic [TIME_W-1:0] last;
		logic [CNT_W-1:0]  count;
	} entry_t;

endpackage

// ===== rtl/can_id_activity_table.sv =====
// CAN identifier activity table.
//
// The slave stream carries one command per transfer in s_tuser (clear, observe,
// lookup) with the identifier, DLC and millisecond time packed in s_tdata. The
// master stream returns exactly one result transfer per command: found and
// dropped flags in m_tuser and the entry record plus the table fill in m_tdata.
//
// Observe and lookup walk the filled entries one per cycle through a single
// registered memory read port and one shared identifier comparator; the walk
// stops early on a hit. Clear and unknown commands skip the walk, as do observe
// and lookup on an empty table. s_tready is high only while the sequencer is
// idle.
//
// The result sits in an output register, so a new command is accepted while the
// previous result still waits; a stalled master side only holds the block once
// the next result is ready and the output register is still occupied.
//
// Reset clears the fill level, the sequencer and the output valid. The entry
// memory is not cleared: only entries below the fill level are ever read.
module can_id_activity_table #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [28:0] can_id, [32:29] frame_dlc, [64:33] time_ms, upper bits zero
	input  logic [can_ida_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [1:0] command
	input  logic [can_ida_pkg::CMD_W-1:0]       s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [3:0] entry_dlc, [35:4] message_count, [67:36] first_seen,
	// [99:68] last_seen, [109:100] unique_count, upper bits zero
	output logic [can_ida_pkg::OUT_TDATA_W-1:0] m_tdata,
	// [0] found, [1] dropped
	output logic [can_ida_pkg::FLAG_W-1:0]      m_tuser
);
	import can_ida_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

	state_t                 state_q;
	logic [CW-1:0]          fill_q;
	logic [CW-1:0]          rd_idx_q;
	logic [AW-1:0]          cmp_idx_q;
	logic                   pend_q;
	logic                   hit_q;
	logic [AW-1:0]          hit_idx_q;
	entry_t                 ent_q;
	entry_t                 rd_q;
	logic [CMD_W-1:0]       cmd_q;
	logic [ID_W-1:0]        id_q;
	logic [DLC_W-1:0]       dlc_q;
	logic [TIME_W-1:0]      time_q;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [FLAG_W-1:0]      m_tuser_q;

	entry_t mem [TABLE_DEPTH];

	logic             accept;
	logic             issue;
	logic             match;
	logic             last_cmp;
	logic             done_fire;
	logic [CW-1:0]    last_idx;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	entry_t           mem_wdata;
	logic             res_found;
	logic             res_drop;
	entry_t           res_ent;
	logic [CW-1:0]    res_fill;
	logic [CNT_W-1:0] inc_count;
	logic [CW+UNIQ_W-1:0] uniq_ext;
	logic [OUT_TDATA_W-1:0] res_tdata;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign accept    = s_tvalid && s_tready;
	assign issue     = (state_q == S_SCAN) && (rd_idx_q < fill_q);
	assign last_idx  = fill_q - CW'(1);
	// The one identifier comparator, fed by the memory read register.
	assign match     = (rd_q.id == id_q);
	assign last_cmp  = (CW'(cmp_idx_q) == last_idx);
	assign done_fire = (state_q == S_DONE) && (!m_tvalid_q || m_tready);
	assign inc_count = (ent_q.count == COUNT_MAX) ? ent_q.count : ent_q.count + CNT_W'(1);

	always_comb begin
		res_found = 1'b0;
		res_drop  = 1'b0;
		res_ent   = '0;
		res_fill  = fill_q;
		mem_we    = 1'b0;
		mem_waddr = hit_idx_q;
		mem_wdata = ent_q;
		case (cmd_q)
			CMD_CLEAR: begin
				res_fill = '0;
			end
			CMD_OBSERVE: begin
				if (hit_q) begin
					res_found       = 1'b1;
					mem_wdata.last  = time_q;
					mem_wdata.count = inc_count;
					res_ent         = mem_wdata;
					mem_we          = done_fire;
				end else if (fill_q < DEPTH_C) begin
					mem_waddr       = fill_q[AW-1:0];
					mem_wdata.id    = id_q;
					mem_wdata.dlc   = dlc_q;
					mem_wdata.first = time_q;
					mem_wdata.last  = time_q;
					mem_wdata.count = CNT_W'(1);
					res_ent         = mem_wdata;
					res_fill        = fill_q + CW'(1);
					mem_we          = done_fire;
				end else begin
					res_drop = 1'b1;
				end
			end
			CMD_LOOKUP: begin
				if (hit_q) begin
					res_found = 1'b1;
					res_ent   = ent_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign uniq_ext  = {{UNIQ_W{1'b0}}, res_fill};
	assign res_tdata = OUT_TDATA_W'({uniq_ext[UNIQ_W-1:0], res_ent.last, res_ent.first,
		res_ent.count, res_ent.dlc});

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rd_q <= mem[rd_idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fill_q     <= '0;
			rd_idx_q   <= '0;
			cmp_idx_q  <= '0;
			pend_q     <= 1'b0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			ent_q      <= '0;
			cmd_q      <= '0;
			id_q       <= '0;
			dlc_q      <= '0;
			time_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			// A new result may load in the same cycle the old one leaves.
			if (done_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= s_tuser;
						id_q     <= s_tdata[ID_W-1:0];
						dlc_q    <= s_tdata[ID_W+DLC_W-1:ID_W];
						time_q   <= s_tdata[IN_FIELDS_W-1:ID_W+DLC_W];
						hit_q    <= 1'b0;
						rd_idx_q <= '0;
						pend_q   <= 1'b0;
						if ((s_tuser == CMD_OBSERVE || s_tuser == CMD_LOOKUP)
							&& fill_q != '0) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					pend_q <= issue;
					if (issue) begin
						cmp_idx_q <= rd_idx_q[AW-1:0];
						rd_idx_q  <= rd_idx_q + CW'(1);
					end
					if (pend_q) begin
						if (match) begin
							hit_q     <= 1'b1;
							hit_idx_q <= cmp_idx_q;
							ent_q     <= rd_q;
							state_q   <= S_DONE;
						end else if (last_cmp) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (done_fire) begin
						fill_q     <= res_fill;
						m_tdata_q  <= res_tdata;
						m_tuser_q  <= {res_drop, res_found};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill level beyond table depth");

	a_pend_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && pend_q) |-> (CW'(cmp_idx_q) < fill_q))
		else $error("compared entry lies above the fill level");

	a_scan_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (cmd_q == CMD_OBSERVE || cmd_q == CMD_LOOKUP))
		else $error("table walk for a command that needs none");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire && res_drop |-> (fill_q == DEPTH_C) && !res_found)
		else $error("identifier dropped while room remains");

	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire && res_found |=> m_tdata_q[DLC_W+CNT_W-1:DLC_W] != '0)
		else $error("hit reported with a zero message count");

endmodule

// ===== sim/can_id_activity_table_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the CAN identifier activity table.
//
// A scoreboard object keeps its own copy of the identifier table and works out
// the one result that every accepted command must produce. The receiving side
// checks every result transfer against the oldest result still pending. The
// stimulus runs in three parts:
// - a short directed run over the field extremes and every command;
// - a fill of the whole table followed by traffic on the full table, so that
//   drops and hits at the far end of the walk are seen;
// - a long random run over a small pool of identifiers with occasional clears,
//   so that hits, misses, lookups and the unused command mix freely.
// Sender gaps and receiver stalls change from phase to phase.
module can_id_activity_table_tb;
	import can_ida_pkg::*;

	localparam int TABLE_DEPTH = 512;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int POOL_SIZE   = 48;
	// The slowest command walks the whole table; the settle time is sized from the depth.
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 80;

	// The fourth command code has no meaning to the block and must be ignored.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Bit offsets of the result fields inside m_tdata.
	localparam int CNT_LSB   = DLC_W;
	localparam int FIRST_LSB = CNT_LSB + CNT_W;
	localparam int LAST_LSB  = FIRST_LSB + TIME_W;
	localparam int UNIQ_LSB  = LAST_LSB + TIME_W;

	localparam logic [ID_W-1:0]   ID_ALL   = {ID_W{1'b1}};
	localparam logic [DLC_W-1:0]  DLC_ALL  = {DLC_W{1'b1}};
	localparam logic [TIME_W-1:0] TIME_ALL = {TIME_W{1'b1}};

	// One expected result, with the command and sequence number kept for the
	// mismatch report.
	typedef struct packed {
		int                 seq;
		logic [CMD_W-1:0]   cmd;
		logic               found;
		logic               dropped;
		logic [DLC_W-1:0]   dlc;
		logic [CNT_W-1:0]   count;
		logic [TIME_W-1:0]  first;
		logic [TIME_W-1:0]  last;
		logic [UNIQ_W-1:0]  uniq;
	} id_report_t;

	class activity_scoreboard;
		entry_t      slots[TABLE_DEPTH];
		int unsigned fill;
		id_report_t  reports_due[$];
		int          errors;
		int          n_accepted;
		int          n_checked;
		int          n_new;
		int          n_hits;
		int          n_drops;
		int          n_lookup_hits;
		int          n_lookup_misses;
		int          n_clears;
		int          n_ignored;

		function int find_slot(logic [ID_W-1:0] id);
			for (int i = 0; i < fill; i++) begin
				if (slots[i].id == id)
					return i;
			end
			return -1;
		endfunction

		// Applies one accepted command to the table copy and queues its result.
		function void note_input(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
				logic [DLC_W-1:0] dlc, logic [TIME_W-1:0] now);
			id_report_t r;
			int         idx;
			r = '0;
			idx = -1;
			r.seq = n_accepted;
			r.cmd = cmd;
			n_accepted++;
			case (cmd)
				CMD_CLEAR: begin
					fill = 0;
					n_clears++;
				end
				CMD_OBSERVE: begin
					idx = find_slot(id);
					if (idx >= 0) begin
						slots[idx].last = now;
						// The count sticks at its maximum but the time still moves.
						if (slots[idx].count != COUNT_MAX)
							slots[idx].count = slots[idx].count + 1'b1;
						r.found = 1'b1;
						n_hits++;
					end else if (fill < TABLE_DEPTH) begin
						idx = fill;
						slots[idx] = '{id: id, dlc: dlc, first: now, last: now, count: 1};
						fill++;
						n_new++;
					end else begin
						r.dropped = 1'b1;
						n_drops++;
					end
				end
				CMD_LOOKUP: begin
					idx = find_slot(id);
					if (idx >= 0) begin
						r.found = 1'b1;
						n_lookup_hits++;
					end else begin
						n_lookup_misses++;
					end
				end
				default: begin
					n_ignored++;
				end
			endcase
			if (idx >= 0) begin
				r.dlc   = slots[idx].dlc;
				r.count = slots[idx].count;
				r.first = slots[idx].first;
				r.last  = slots[idx].last;
			end
			r.uniq = UNIQ_W'(fill);
			reports_due.push_back(r);
		endfunction

		function void compare(id_report_t e, string what, logic [63:0] want,
				logic [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: item %0d (command %0d) %s expected 0x%0h, got 0x%0h",
					$time, e.seq, e.cmd, what, want, got);
			end
		endfunction

		function void check_result(logic [FLAG_W-1:0] flags,
				logic [OUT_TDATA_W-1:0] word);
			id_report_t e;
			if (reports_due.size() == 0) begin
				errors++;
				$display("%0t: stray result, expected none, got tuser 0x%0h tdata 0x%0h",
					$time, flags, word);
				return;
			end
			e = reports_due.pop_front();
			n_checked++;
			compare(e, "found", e.found, flags[0]);
			compare(e, "dropped", e.dropped, flags[1]);
			compare(e, "entry_dlc", e.dlc, word[0 +: DLC_W]);
			compare(e, "message_count", e.count, word[CNT_LSB +: CNT_W]);
			compare(e, "first_seen", e.first, word[FIRST_LSB +: TIME_W]);
			compare(e, "last_seen", e.last, word[LAST_LSB +: TIME_W]);
			compare(e, "unique_count", e.uniq, word[UNIQ_LSB +: UNIQ_W]);
			compare(e, "tdata padding", '0, word[OUT_TDATA_W-1:OUT_FIELDS_W]);
		endfunction

		function int pending();
			return reports_due.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [CMD_W-1:0]       s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [FLAG_W-1:0]      m_tuser;

	activity_scoreboard sb = new;

	// Percent chance, per cycle, that the sender holds back or the receiver stalls.
	int send_idle_pct;
	int stall_pct;

	logic [ID_W-1:0] id_pool[POOL_SIZE];
	logic [ID_W-1:0] filled_ids[TABLE_DEPTH];

	can_id_activity_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiving side: checks each result transfer and then decides whether to
	// stall in the coming cycle. Signals are read before this edge's updates land.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Hard stop in case the block hangs. A full table walk per item for every
	// item, with stalls and gaps, stays well below this.
	initial begin
		#16_000_000;
		$display("can_id_activity_table_tb: done, errors");
		$finish;
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct     = recv_pct;
	endtask

	// Offers one command and returns at the edge where it was accepted. The
	// valid stays high on return so that a following item goes out back to back.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
			input logic [DLC_W-1:0] dlc, input logic [TIME_W-1:0] now);
		logic [IN_TDATA_W-1:0] word;
		word = '0;
		word[IN_FIELDS_W-1:0] = {now, dlc, id};
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_input(cmd, id, dlc, now);
	endtask

	// Holds the sender off until every pending result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// One random command: mostly observes and lookups on a small pool of
	// identifiers, so that both hits and misses are common, with the odd clear.
	task automatic random_item();
		int               roll;
		logic [CMD_W-1:0] cmd;
		logic [ID_W-1:0]  id;
		roll = $urandom_range(99);
		if (roll < 3)
			cmd = CMD_CLEAR;
		else if (roll < 63)
			cmd = CMD_OBSERVE;
		else if (roll < 95)
			cmd = CMD_LOOKUP;
		else
			cmd = CMD_UNUSED;
		roll = $urandom_range(99);
		if (roll < 70)
			id = id_pool[$urandom_range(POOL_SIZE - 1)];
		else if (roll < 80)
			id = ID_W'($urandom_range(11'h7FF));
		else
			id = ID_W'($urandom);
		send_item(cmd, id, DLC_W'($urandom), $urandom);
	endtask

	// Traffic on a full table: drops of new identifiers, hits anywhere in the
	// table (often on the last entry, at the end of the walk) and lookups.
	task automatic full_table_item();
		int              roll;
		logic [ID_W-1:0] id;
		roll = $urandom_range(99);
		if (roll < 40) begin
			send_item(CMD_OBSERVE, ID_W'($urandom), DLC_W'($urandom), $urandom);
		end else if (roll < 65) begin
			if ($urandom_range(1) == 0)
				id = filled_ids[TABLE_DEPTH - 1];
			else
				id = filled_ids[$urandom_range(TABLE_DEPTH - 1)];
			send_item(CMD_OBSERVE, id, DLC_W'($urandom), $urandom);
		end else if (roll < 85) begin
			send_item(CMD_LOOKUP, filled_ids[$urandom_range(TABLE_DEPTH - 1)],
				DLC_W'($urandom), $urandom);
		end else begin
			send_item(CMD_LOOKUP, ID_W'($urandom), DLC_W'($urandom), $urandom);
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= CMD_CLEAR;
		set_idling(0, 0);
		for (int i = 0; i < POOL_SIZE; i++)
			id_pool[i] = ID_W'($urandom);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with no idling on either side.
		send_item(CMD_LOOKUP, ID_ALL, DLC_ALL, TIME_ALL);           // empty table
		send_item(CMD_OBSERVE, '0, '0, '0);                         // new, all zero
		send_item(CMD_OBSERVE, ID_ALL, DLC_ALL, TIME_ALL);          // new, all ones
		send_item(CMD_OBSERVE, '0, DLC_ALL, TIME_ALL);              // hit keeps first DLC
		send_item(CMD_OBSERVE, ID_ALL, '0, '0);                     // hit, time goes back
		send_item(CMD_LOOKUP, '0, DLC_ALL, TIME_ALL);
		send_item(CMD_LOOKUP, ID_ALL, '0, '0);
		send_item(CMD_LOOKUP, ID_ALL - 1'b1, '0, '0);               // near miss
		send_item(CMD_UNUSED, ID_ALL, DLC_ALL, TIME_ALL);
		send_item(CMD_OBSERVE, ID_W'(11'h7FF), 4'd8, 32'h0000_1000);// standard 11-bit id
		send_item(CMD_OBSERVE, ID_W'(11'h7FF), 4'd3, 32'h0000_1001);
		send_item(CMD_CLEAR, ID_ALL, DLC_ALL, TIME_ALL);
		send_item(CMD_LOOKUP, '0, '0, '0);                          // gone after clear
		send_item(CMD_OBSERVE, '0, 4'd5, 32'h8000_0000);            // slot reused
		send_item(CMD_UNUSED, '0, '0, '0);
		wait_drained();

		// Fill the whole table. The low bits of each identifier hold its index,
		// which keeps the identifiers distinct.
		set_idling(77, 0);
		send_item(CMD_CLEAR, ID_W'($urandom), DLC_W'($urandom), $urandom);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			filled_ids[i] = ID_W'(($urandom << IDX_W) | i);
			send_item(CMD_OBSERVE, filled_ids[i], DLC_W'($urandom), $urandom);
		end
		set_idling(8, 8);
		for (int i = 0; i < 40; i++)
			full_table_item();
		wait_drained();

		// Random part: each idling mode in turn, starting with none.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_idling(0, 0);
				1: set_idling(77, 0);
				2: set_idling(0, 77);
				default: set_idling(8, 8);
			endcase
			send_item(CMD_CLEAR, ID_W'($urandom), DLC_W'($urandom), $urandom);
			for (int i = 0; i < 150; i++)
				random_item();
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d commands, %0d results checked: %0d clears, %0d ignored codes.",
			sb.n_accepted, sb.n_checked, sb.n_clears, sb.n_ignored);
		$display("Observes: %0d new, %0d hits, %0d dropped; lookups: %0d hits, %0d misses.",
			sb.n_new, sb.n_hits, sb.n_drops, sb.n_lookup_hits, sb.n_lookup_misses);
		if (sb.errors == 0)
			$display("can_id_activity_table_tb: done, clean");
		else
			$display("can_id_activity_table_tb: done, errors");
		$finish;
	end

endmodule

// ===== can_id_activity_table.f =====
rtl/can_ida_pkg.sv
rtl/can_id_activity_table.sv
sim/can_id_activity_table_tb.sv
